### rtl/ipsc_pkg.sv
// Package for the inverse Park / SVPWM compare block.
// Holds shared widths, register indexes, reset values and the phase sign struct.
// No dependencies.
package ipsc_pkg;

    // Default fixed-point formats and compare width.
    localparam int VOLT_FRAC_BITS_DEF = 12;
    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int COMPARE_WIDTH_DEF  = 16;

    // Field and register widths.
    localparam int DATA_W      = 16;
    localparam int CFG_INDEX_W = 2;

    // Internal datapath widths. The alpha/beta sums need 33 bits, the
    // phases stay below 2^48 in magnitude and the output voltages below 2^49.
    localparam int ALPHA_W = 2 * DATA_W + 1;
    localparam int KMUL_W  = 17;
    localparam int PHASE_W = ALPHA_W + KMUL_W;
    localparam int W_W     = PHASE_W + 1;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_VOLTAGE   = 2'd1;

    // Register reset values.
    localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [DATA_W-1:0] BUS_RESET    = 16'd13517;

    // sqrt(3)/2 in Q16.
    localparam logic signed [KMUL_W-1:0] SQRT3_HALF_Q16 = 17'sd56756;

    // Sign information per phase: bit i belongs to phase i (A, B, C).
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] nonzero;
    } phase_sign_t;

endpackage

### rtl/ipsc_transform.sv
// Inverse Park and inverse Clarke transform, four pipeline stages.
// Depends on ipsc_pkg for widths and the sqrt(3)/2 constant.
module ipsc_transform (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ipsc_pkg::DATA_W-1:0]    voltage_q,
    input  logic signed [ipsc_pkg::DATA_W-1:0]    voltage_d,
    input  logic signed [ipsc_pkg::DATA_W-1:0]    sine_angle,
    input  logic signed [ipsc_pkg::DATA_W-1:0]    cosine_angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ipsc_pkg::PHASE_W-1:0]   phase_a,
    output logic signed [ipsc_pkg::PHASE_W-1:0]   phase_b,
    output logic signed [ipsc_pkg::PHASE_W-1:0]   phase_c
);
    import ipsc_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [PROD_W-1:0]  prod_cd_reg, prod_sq_reg, prod_cq_reg, prod_sd_reg;
    logic signed [PROD_W-1:0]  prod_cd_next, prod_sq_next, prod_cq_next, prod_sd_next;
    logic signed [ALPHA_W-1:0] alpha_reg, beta_reg, alpha_next, beta_next;
    logic signed [ALPHA_W-1:0] alpha3_reg;
    logic signed [PHASE_W-1:0] beta_k_reg, beta_k_next;
    logic signed [PHASE_W-1:0] pa_reg, pb_reg, pc_reg, pa_next, pb_next, pc_next;
    logic signed [PHASE_W-1:0] half_alpha;

    // Each stage moves when it is empty or the stage after it moves.
    assign en4      = ~v4_reg | out_ready;
    assign en3      = ~v3_reg | en4;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;

    // Stage 1: the four angle products.
    assign prod_cd_next = cosine_angle * voltage_d;
    assign prod_sq_next = sine_angle * voltage_q;
    assign prod_cq_next = cosine_angle * voltage_q;
    assign prod_sd_next = sine_angle * voltage_d;

    // Stage 2: alpha and beta.
    assign alpha_next = ALPHA_W'(prod_cd_reg) - ALPHA_W'(prod_sq_reg);
    assign beta_next  = ALPHA_W'(prod_cq_reg) + ALPHA_W'(prod_sd_reg);

    // Stage 3: beta scaled by sqrt(3)/2.
    assign beta_k_next = PHASE_W'(beta_reg) * PHASE_W'(SQRT3_HALF_Q16);

    // Stage 4: the three phase voltages.
    assign half_alpha = $signed({{(PHASE_W-ALPHA_W-15){alpha3_reg[ALPHA_W-1]}},
                                 alpha3_reg, 15'b0});
    assign pa_next = $signed({{(PHASE_W-ALPHA_W-16){alpha3_reg[ALPHA_W-1]}},
                              alpha3_reg, 16'b0});
    assign pb_next = beta_k_reg - half_alpha;
    assign pc_next = -half_alpha - beta_k_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_cd_reg <= prod_cd_next;
            prod_sq_reg <= prod_sq_next;
            prod_cq_reg <= prod_cq_next;
            prod_sd_reg <= prod_sd_next;
        end
        if (en2)
        begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
        if (en3)
        begin
            alpha3_reg <= alpha_reg;
            beta_k_reg <= beta_k_next;
        end
        if (en4)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
    end

    assign out_valid = v4_reg;
    assign phase_a   = pa_reg;
    assign phase_b   = pb_reg;
    assign phase_c   = pc_reg;

endmodule

### rtl/ipsc_neutral.sv
// Min-max neutral removal and output voltage magnitude, two pipeline stages.
// Depends on ipsc_pkg for widths and the phase sign struct.
module ipsc_neutral #(
    parameter int VOLT_FRAC_BITS = ipsc_pkg::VOLT_FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS = ipsc_pkg::TRIG_FRAC_BITS_DEF,
    parameter int MAG_W          = ipsc_pkg::W_W - 2 - VOLT_FRAC_BITS - TRIG_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ipsc_pkg::PHASE_W-1:0]  phase_a,
    input  logic signed [ipsc_pkg::PHASE_W-1:0]  phase_b,
    input  logic signed [ipsc_pkg::PHASE_W-1:0]  phase_c,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [MAG_W-1:0]                     mag_a,
    output logic [MAG_W-1:0]                     mag_b,
    output logic [MAG_W-1:0]                     mag_c,
    output ipsc_pkg::phase_sign_t                sign_info
);
    import ipsc_pkg::*;

    localparam int SHIFT = VOLT_FRAC_BITS + TRIG_FRAC_BITS + 1;

    logic v1_reg, v2_reg;
    logic en1, en2;

    logic signed [W_W-1:0] p_reg [3];
    logic signed [W_W-1:0] p_in [3];
    logic signed [W_W-1:0] mid2_reg, mid2_next;
    logic signed [W_W-1:0] w [3];
    logic signed [PHASE_W-1:0] mx_ab, mn_ab, mx, mn;
    logic [MAG_W-1:0] mag_reg [3];
    logic [MAG_W-1:0] mag_next [3];
    phase_sign_t sign_reg, sign_next;

    assign en2      = ~v2_reg | out_ready;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;

    // Stage 1: max plus min of the three phases.
    assign mx_ab     = (phase_a > phase_b) ? phase_a : phase_b;
    assign mx        = (mx_ab > phase_c) ? mx_ab : phase_c;
    assign mn_ab     = (phase_a < phase_b) ? phase_a : phase_b;
    assign mn        = (mn_ab < phase_c) ? mn_ab : phase_c;
    assign mid2_next = W_W'(mx) + W_W'(mn);
    assign p_in[0]   = W_W'(phase_a);
    assign p_in[1]   = W_W'(phase_b);
    assign p_in[2]   = W_W'(phase_c);

    // Stage 2: output voltage, its sign and its truncated magnitude.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w[i]                 = (p_reg[i] <<< 1) - mid2_reg;
            sign_next.neg[i]     = w[i][W_W-1];
            sign_next.nonzero[i] = |w[i];
            mag_next[i]          = w[i][W_W-2:SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_reg    <= p_in;
            mid2_reg <= mid2_next;
        end
        if (en2)
        begin
            mag_reg  <= mag_next;
            sign_reg <= sign_next;
        end
    end

    assign out_valid = v2_reg;
    assign mag_a     = mag_reg[0];
    assign mag_b     = mag_reg[1];
    assign mag_c     = mag_reg[2];
    assign sign_info = sign_reg;

endmodule

### rtl/ipsc_scale.sv
// Bus voltage and period scaling with saturation, three pipeline stages.
// Depends on ipsc_pkg for widths and the phase sign struct.
module ipsc_scale #(
    parameter int VOLT_FRAC_BITS = ipsc_pkg::VOLT_FRAC_BITS_DEF,
    parameter int COMPARE_WIDTH  = ipsc_pkg::COMPARE_WIDTH_DEF,
    parameter int MAG_W          = 23
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [MAG_W-1:0]                  mag_a,
    input  logic [MAG_W-1:0]                  mag_b,
    input  logic [MAG_W-1:0]                  mag_c,
    input  ipsc_pkg::phase_sign_t             sign_info,
    input  logic [ipsc_pkg::DATA_W-1:0]       compare_period,
    input  logic [ipsc_pkg::DATA_W-1:0]       link_voltage,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ipsc_pkg::DATA_W-1:0]       compare_a,
    output logic [ipsc_pkg::DATA_W-1:0]       compare_b,
    output logic [ipsc_pkg::DATA_W-1:0]       compare_c,
    output logic [2:0]                        clip_flags
);
    import ipsc_pkg::*;

    localparam int BM_W  = DATA_W + MAG_W;
    localparam int QW    = BM_W - VOLT_FRAC_BITS;
    localparam int Q_CAP = 33;
    localparam int CQ_W  = Q_CAP + DATA_W;
    localparam int C_W   = CQ_W - 17;
    localparam logic [DATA_W-1:0] LIMIT_MASK = (COMPARE_WIDTH >= DATA_W) ?
        {DATA_W{1'b1}} : DATA_W'((64'd1 << COMPARE_WIDTH) - 64'd1);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [MAG_W-1:0]  mag_in [3];
    logic [BM_W-1:0]   bm_reg [3];
    logic [BM_W-1:0]   bm_next [3];
    logic [CQ_W-1:0]   cq_reg [3];
    logic [CQ_W-1:0]   cq_next [3];
    logic [QW-1:0]     q [3];
    logic [63:0]       q_ext [3];
    logic [2:0]        big_reg, big_next;
    phase_sign_t       sign1_reg, sign2_reg;
    logic [DATA_W-1:0] res_reg [3];
    logic [DATA_W-1:0] res_next [3];
    logic [2:0]        flag_reg, flag_next;
    logic [C_W-1:0]    c_val [3];
    logic [DATA_W-1:0] limit;
    logic              active;

    assign en3      = ~v3_reg | out_ready;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;

    assign mag_in[0] = mag_a;
    assign mag_in[1] = mag_b;
    assign mag_in[2] = mag_c;

    assign limit  = compare_period & LIMIT_MASK;
    assign active = (link_voltage != '0) && (compare_period != '0);

    // Stage 1: magnitude times bus voltage.
    // Stage 2: drop the voltage fraction, then multiply by the period.
    // Stage 3: take the compare count and saturate it.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bm_next[i]  = BM_W'(link_voltage) * BM_W'(mag_in[i]);
            q[i]        = bm_reg[i][BM_W-1:VOLT_FRAC_BITS];
            q_ext[i]    = 64'(q[i]);
            big_next[i] = |q_ext[i][63:Q_CAP];
            cq_next[i]  = CQ_W'(q_ext[i][Q_CAP-1:0]) * CQ_W'(compare_period);
            c_val[i]    = cq_reg[i][CQ_W-1:17];
            if (!sign2_reg.nonzero[i] || !active)
            begin
                res_next[i]  = '0;
                flag_next[i] = 1'b0;
            end
            else if (sign2_reg.neg[i])
            begin
                res_next[i]  = '0;
                flag_next[i] = 1'b1;
            end
            else if (big_reg[i] || (c_val[i] > C_W'(limit)))
            begin
                res_next[i]  = limit;
                flag_next[i] = 1'b1;
            end
            else
            begin
                res_next[i]  = c_val[i][DATA_W-1:0];
                flag_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            bm_reg    <= bm_next;
            sign1_reg <= sign_info;
        end
        if (en2)
        begin
            cq_reg    <= cq_next;
            big_reg   <= big_next;
            sign2_reg <= sign1_reg;
        end
        if (en3)
        begin
            res_reg  <= res_next;
            flag_reg <= flag_next;
        end
    end

    assign out_valid  = v3_reg;
    assign compare_a  = res_reg[0];
    assign compare_b  = res_reg[1];
    assign compare_c  = res_reg[2];
    assign clip_flags = flag_reg;

endmodule

### rtl/inverse_park_svpwm_compare.sv
// Nine register stages lie between an accepted command and its result on the
// outputs.
// One command per cycle while res_ready stays high; each stage holds one item and moves
// whenever it is empty or the stage after it moves.
// Reset clears all stage valid bits and loads compare_period = 1000 and
// link_voltage = 13517; data registers are not reset.
// Top level: configuration registers and the transform, neutral and scale
// pipeline sections. Depends on ipsc_pkg and the three ipsc_* modules.
module inverse_park_svpwm_compare #(
    parameter int VOLT_FRAC_BITS = ipsc_pkg::VOLT_FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS = ipsc_pkg::TRIG_FRAC_BITS_DEF,
    parameter int COMPARE_WIDTH  = ipsc_pkg::COMPARE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ipsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ipsc_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic signed [ipsc_pkg::DATA_W-1:0]  voltage_q,
    input  logic signed [ipsc_pkg::DATA_W-1:0]  voltage_d,
    input  logic signed [ipsc_pkg::DATA_W-1:0]  sine_angle,
    input  logic signed [ipsc_pkg::DATA_W-1:0]  cosine_angle,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [ipsc_pkg::DATA_W-1:0]         compare_a,
    output logic [ipsc_pkg::DATA_W-1:0]         compare_b,
    output logic [ipsc_pkg::DATA_W-1:0]         compare_c,
    output logic [2:0]                          clip_flags
);
    import ipsc_pkg::*;

    localparam int MAG_W = W_W - 2 - VOLT_FRAC_BITS - TRIG_FRAC_BITS;

    logic [DATA_W-1:0] period_reg, bus_reg;

    logic                      tr_valid, tr_ready;
    logic signed [PHASE_W-1:0] pa, pb, pc;
    logic                      nt_valid, nt_ready;
    logic [MAG_W-1:0]          ma, mb, mc;
    phase_sign_t               sign_info;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            bus_reg    <= BUS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COMPARE_PERIOD: period_reg <= cfg_data;
                REG_LINK_VOLTAGE:   bus_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Inverse Park and Clarke transform.
    ipsc_transform u_transform (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd_valid),
        .in_ready     (cmd_ready),
        .voltage_q    (voltage_q),
        .voltage_d    (voltage_d),
        .sine_angle   (sine_angle),
        .cosine_angle (cosine_angle),
        .out_valid    (tr_valid),
        .out_ready    (tr_ready),
        .phase_a      (pa),
        .phase_b      (pb),
        .phase_c      (pc)
    );

    // Zero-sequence injection.
    ipsc_neutral #(
        .VOLT_FRAC_BITS (VOLT_FRAC_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .MAG_W          (MAG_W)
    ) u_neutral (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tr_valid),
        .in_ready  (tr_ready),
        .phase_a   (pa),
        .phase_b   (pb),
        .phase_c   (pc),
        .out_valid (nt_valid),
        .out_ready (nt_ready),
        .mag_a     (ma),
        .mag_b     (mb),
        .mag_c     (mc),
        .sign_info (sign_info)
    );

    // Compare scaling and saturation.
    ipsc_scale #(
        .VOLT_FRAC_BITS (VOLT_FRAC_BITS),
        .COMPARE_WIDTH  (COMPARE_WIDTH),
        .MAG_W          (MAG_W)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (nt_valid),
        .in_ready       (nt_ready),
        .mag_a          (ma),
        .mag_b          (mb),
        .mag_c          (mc),
        .sign_info      (sign_info),
        .compare_period (period_reg),
        .link_voltage   (bus_reg),
        .out_valid      (res_valid),
        .out_ready      (res_ready),
        .compare_a      (compare_a),
        .compare_b      (compare_b),
        .compare_c      (compare_c),
        .clip_flags     (clip_flags)
    );

endmodule

### test/tb.sv
// Self-checking testbench for inverse_park_svpwm_compare: drives voltage commands
// through the request handshake and compares every compare set with a hand-worked result or a local predictor.
// Depends on ipsc_pkg and the inverse_park_svpwm_compare RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipsc_pkg::*;

    // Register indexes that the block does not implement; writes must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int PIPE_GUARD     = 12;
    localparam int HOLD_CYCLES    = 60;
    localparam int HOLD_PHASE     = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_COUNT    = 10;
    localparam int RANDOM_COUNT   = 114;
    localparam int SCALE_SHIFT    = VOLT_FRAC_BITS_DEF + TRIG_FRAC_BITS_DEF + 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] voltage_q;
        logic signed [DATA_W-1:0] voltage_d;
        logic signed [DATA_W-1:0] sine_angle;
        logic signed [DATA_W-1:0] cosine_angle;
    } voltage_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] compare_a;
        logic [DATA_W-1:0] compare_b;
        logic [DATA_W-1:0] compare_c;
        logic [2:0]        clip_flags;
    } compare_set_t;

    typedef struct packed {
        logic              clip;
        logic [DATA_W-1:0] value;
    } phase_compare_t;

    // One directed row: the command, and a hand-worked result where typed is set.
    typedef struct packed {
        voltage_cmd_t cmd;
        logic         typed;
        compare_set_t want;
    } directed_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] bus;
        int                count;
    } setting_t;

    localparam int DIRECTED_COUNT = 16;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Zero command gives zero voltage on every phase: no compare, no flag.
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 16'd0, 16'd0, 3'd0}},
        // 1 V on d at angle zero: phase A clips high, B and C clip low.
        '{'{16'sd0, 16'sd4096, 16'sd0, 16'sd16384}, 1'b1,
          '{16'd1000, 16'd0, 16'd0, 3'd7}},
        // Mirror image: A low, B and C clip high.
        '{'{16'sd0, -16'sd4096, 16'sd0, 16'sd16384}, 1'b1,
          '{16'd0, 16'd1000, 16'd1000, 3'd7}},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sd16384, 16'sd16384}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000, -16'sd16384, -16'sd16384}, 1'b0, '0},
        '{'{16'sh8000, 16'sh7FFF, 16'sd16384, 16'sd0}, 1'b0, '0},
        // Trig values outside the unit range are taken as given.
        '{'{16'sd1000, -16'sd2000, 16'sh8000, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0, '0},
        '{'{16'sd1, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
        '{'{16'sd100, 16'sd50, 16'sd11585, 16'sd11585}, 1'b0, '0},
        '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b0, '0},
        '{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{'{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b0, '0},
        '{'{16'sd2048, 16'sd0, 16'sd8192, 16'sd14189}, 1'b0, '0},
        '{'{16'sd4096, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0},
        '{'{16'sd300, -16'sd200, -16'sd9000, 16'sd13000}, 1'b0, '0}
    };

    // Fixed settings first (extremes, zero period, zero bus, reset values),
    // then random ones.
    localparam setting_t FIXED_SETTINGS [5] = '{
        '{16'd65535, 16'd65535, 60},
        '{16'd1, 16'd1, 40},
        '{16'd0, 16'd13517, 40},
        '{16'd1000, 16'd0, 40},
        '{16'd1000, 16'd13517, 150}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    logic signed [DATA_W-1:0] voltage_q = '0;
    logic signed [DATA_W-1:0] voltage_d = '0;
    logic signed [DATA_W-1:0] sine_angle = '0;
    logic signed [DATA_W-1:0] cosine_angle = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [DATA_W-1:0] compare_a;
    logic [DATA_W-1:0] compare_b;
    logic [DATA_W-1:0] compare_c;
    logic [2:0] clip_flags;

    // Local copy of the block's registers.
    logic [DATA_W-1:0] period_reg = PERIOD_RESET;
    logic [DATA_W-1:0] bus_reg = BUS_RESET;

    compare_set_t pending_compares [$];
    int failures = 0;
    int stall_cycles = 0;
    bit steady_traffic = 1'b0;
    bit hold_request = 1'b0;

    inverse_park_svpwm_compare i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .voltage_q    (voltage_q),
        .voltage_d    (voltage_d),
        .sine_angle   (sine_angle),
        .cosine_angle (cosine_angle),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .compare_a    (compare_a),
        .compare_b    (compare_b),
        .compare_c    (compare_c),
        .clip_flags   (clip_flags)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Scale one neutral-shifted phase voltage into a compare count.
    function automatic phase_compare_t phase_to_compare(input longint volts);
        longint unsigned mag;
        longint unsigned scaled;
        longint unsigned count;
        phase_compare_t r;
        r = '0;
        if (volts == 0 || bus_reg == 0 || period_reg == 0)
            return r;
        r.clip = 1'b1;
        if (volts < 0)
            return r;
        mag = volts;
        mag = mag >> SCALE_SHIFT;
        scaled = (bus_reg * mag) >> VOLT_FRAC_BITS_DEF;
        count = (scaled * period_reg) >> 17;
        if (scaled >= (64'd1 << 33) || count > period_reg)
        begin
            r.value = period_reg;
            return r;
        end
        r.clip = 1'b0;
        r.value = count[DATA_W-1:0];
        return r;
    endfunction

    // Inverse Park, inverse Clarke, min-max neutral removal, then scaling.
    function automatic compare_set_t predict_compares(input voltage_cmd_t cmd);
        longint alpha;
        longint beta;
        longint hi;
        longint lo;
        longint phase [3];
        phase_compare_t scaled [3];
        compare_set_t r;
        alpha = longint'(cmd.cosine_angle) * longint'(cmd.voltage_d)
              - longint'(cmd.sine_angle) * longint'(cmd.voltage_q);
        beta  = longint'(cmd.cosine_angle) * longint'(cmd.voltage_q)
              + longint'(cmd.sine_angle) * longint'(cmd.voltage_d);
        phase[0] = alpha * 65536;
        phase[1] = -alpha * 32768 + beta * longint'(SQRT3_HALF_Q16);
        phase[2] = -alpha * 32768 - beta * longint'(SQRT3_HALF_Q16);
        hi = phase[0];
        lo = phase[0];
        for (int i = 1; i < 3; i++)
        begin
            if (phase[i] > hi)
                hi = phase[i];
            if (phase[i] < lo)
                lo = phase[i];
        end
        for (int i = 0; i < 3; i++)
            scaled[i] = phase_to_compare(2 * phase[i] - (hi + lo));
        r.compare_a  = scaled[0].value;
        r.compare_b  = scaled[1].value;
        r.compare_c  = scaled[2].value;
        r.clip_flags = {scaled[2].clip, scaled[1].clip, scaled[0].clip};
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hC000;
            4: return 16'h4000;
            5: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Mostly unit-circle angles with voltages of mixed size, some raw patterns,
    // some corner values.
    function automatic voltage_cmd_t random_command();
        voltage_cmd_t cmd;
        real angle;
        int sel;
        int span;
        sel = $urandom_range(99);
        if (sel < 65)
        begin
            angle = $urandom_range(65535) * 6.283185307179586 / 65536.0;
            span = (sel < 40) ? 2048 : ((sel < 55) ? 8192 : 32767);
            cmd.sine_angle   = DATA_W'($rtoi(16384.0 * $sin(angle)));
            cmd.cosine_angle = DATA_W'($rtoi(16384.0 * $cos(angle)));
            cmd.voltage_q    = DATA_W'($urandom_range(2 * span) - span);
            cmd.voltage_d    = DATA_W'($urandom_range(2 * span) - span);
        end
        else if (sel < 85)
        begin
            cmd.voltage_q    = DATA_W'($urandom());
            cmd.voltage_d    = DATA_W'($urandom());
            cmd.sine_angle   = DATA_W'($urandom());
            cmd.cosine_angle = DATA_W'($urandom());
        end
        else
        begin
            cmd.voltage_q    = corner_value();
            cmd.voltage_d    = corner_value();
            cmd.sine_angle   = corner_value();
            cmd.cosine_angle = corner_value();
        end
        return cmd;
    endfunction

    // Write one register; the caller lowers cfg_write after its last write.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_COMPARE_PERIOD: period_reg = value;
            REG_LINK_VOLTAGE:   bus_reg = value;
            default: ;
        endcase
    endtask

    // Offer one request, hold it until accepted, then record its expected result.
    task automatic send_command(input voltage_cmd_t cmd, input compare_set_t want);
        while (!steady_traffic && $urandom_range(99) < 19)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        voltage_q    <= cmd.voltage_q;
        voltage_d    <= cmd.voltage_d;
        sine_angle   <= cmd.sine_angle;
        cosine_angle <= cmd.cosine_angle;
        @(negedge clk);
        while (!cmd_ready)
            @(negedge clk);
        @(posedge clk);
        pending_compares.push_back(want);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_compares.size() != 0)
            @(posedge clk);
        repeat (PIPE_GUARD) @(posedge clk);
    endtask

    // Receiver: random back-pressure, one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                res_ready <= steady_traffic || ($urandom_range(99) >= 19);
        end
    end

    // Result check, sampled on the falling edge before the accepting edge.
    always @(negedge clk)
    begin
        compare_set_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_compares.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Result with no request pending: a=%0d b=%0d c=%0d flags=%b",
                             compare_a, compare_b, compare_c, clip_flags);
            end
            else
            begin
                want = pending_compares.pop_front();
                if (want.compare_a !== compare_a || want.compare_b !== compare_b ||
                    want.compare_c !== compare_c || want.clip_flags !== clip_flags)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display({"Mismatch: expected a=%0d b=%0d c=%0d flags=%b, ",
                                  "got a=%0d b=%0d c=%0d flags=%b"},
                                 want.compare_a, want.compare_b, want.compare_c,
                                 want.clip_flags, compare_a, compare_b, compare_c,
                                 clip_flags);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(negedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial
    begin
        setting_t setting;
        voltage_cmd_t cmd;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            cmd = DIRECTED_ROWS[r].cmd;
            send_command(cmd, DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].want
                                                     : predict_compares(cmd));
        end
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < 5)
                setting = FIXED_SETTINGS[p];
            else
            begin
                setting.period = DATA_W'($urandom_range(1, 65535));
                setting.bus    = DATA_W'($urandom_range(65535));
                setting.count  = RANDOM_COUNT;
            end
            write_register(REG_COMPARE_PERIOD, setting.period);
            write_register(REG_LINK_VOLTAGE, setting.bus);
            write_register(REG_SPARE_2, DATA_W'($urandom()));
            write_register(REG_SPARE_3, DATA_W'($urandom()));
            cfg_write <= 1'b0;
            steady_traffic = (p == HOLD_PHASE);
            for (int i = 0; i < setting.count; i++)
            begin
                // Stall the receiver while the sender keeps pushing.
                if (p == HOLD_PHASE && i == 30)
                    hold_request = 1'b1;
                cmd = random_command();
                send_command(cmd, predict_compares(cmd));
            end
            drain_results();
            steady_traffic = 1'b0;
        end

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
